// ===== hw/rtl/assert_macros.svh =====
// Assertion macros included by the decoder back end.
// Depends on nothing; each takes a label, clock, reset, check and error message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert a property on the rising clock edge, disabled while reset is low.
`define ASSERT_CLK(lbl, clk_s, rstn_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) else $error(msg);
// Assert that a condition is never true on a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk_s, rstn_s, cond, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(cond)) else $error(msg);
`endif

// ===== hw/rtl/ped_pkg.sv =====
// Package for the peeling erasure decoder: sizes, payload structs and helpers.
// Depends on nothing; imported by the top, front end and back end modules.
`default_nettype none
package ped_pkg;
    localparam int NUM_POSITIONS = 256;
    localparam int PENDING_SLOTS = 64;
    localparam int MASK_BITS     = 256;
    localparam int SLOT_W        = $clog2(PENDING_SLOTS);
    localparam int CNT_W         = 9;
    localparam int PEND_W        = 7;
    localparam int POP_W         = 9;
    localparam int PADDR_W       = 2;
    localparam logic [PADDR_W-1:0] REG_TARGET_LEN = '0;

    typedef struct packed {
        logic [31:0] mask_w7;
        logic [31:0] mask_w6;
        logic [31:0] mask_w5;
        logic [31:0] mask_w4;
        logic [31:0] mask_w3;
        logic [31:0] mask_w2;
        logic [31:0] mask_w1;
        logic [31:0] mask_w0;
        logic        restart;
    } in_item_t;

    typedef struct packed {
        logic [8:0] new_info_count;
        logic [8:0] decoded_count;
        logic [6:0] pending_count;
        logic       overflow;
        logic       complete;
    } out_item_t;

    typedef struct packed {
        logic [MASK_BITS-1:0] mask;
        logic                 restart;
    } cmd_t;

    function automatic logic [MASK_BITS-1:0] pos_limit();
        logic [MASK_BITS-1:0] m;
        for (int i = 0; i < MASK_BITS; i++) begin
            m[i] = (i < NUM_POSITIONS);
        end
        return m;
    endfunction

    // Population count of a 64-bit word.
    function automatic logic [6:0] pop64(input logic [63:0] v);
        logic [6:0] n;
        n = '0;
        for (int i = 0; i < 64; i++) begin
            n = n + 7'(v[i]);
        end
        return n;
    endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/peeling_erasure_decoder_top.sv =====
// Top level of the peeling erasure decoder: APB register, front end and back end.
// Depends on ped_pkg, ped_front and ped_back.
// An ignored request goes straight to the result; others count uncovered positions, then
// report if none are new or the store overflows, store the packet, or decode a singleton
// and rescan slots until a pass decodes nothing. One request at a time in the back end.
// Reset clears the decoded mask, pending valid bits and counts; the target length is 256.
`default_nettype none
module peeling_erasure_decoder_top import ped_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire in_item_t           in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output out_item_t               out_data,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    logic [8:0] path_reg;
    logic       cmd_valid, cmd_ready;
    cmd_t       cmd;

    // The only register, the target length, sits at address zero.
    assign pready = 1'b1;
    assign prdata = (paddr == REG_TARGET_LEN) ? {23'd0, path_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            path_reg <= 9'd256;
        end
        else if (psel && penable && pwrite && paddr == REG_TARGET_LEN)
        begin
            path_reg <= pwdata[8:0];
        end
    end

    // The front end buffers requests while the back end peels.
    ped_front u_front (
        .clk(clk), .rst_n(rst_n), .valid(in_valid), .ready(in_ready),
        .in_item(in_data), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
    );

    ped_back u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
        .cmd(cmd), .target_len(path_reg), .out_valid(out_valid),
        .out_ready(out_ready), .out_item(out_data)
    );
endmodule
`default_nettype wire

// ===== hw/rtl/ped_ram.sv =====
// Generic single-port RAM with registered read data.
// Depends on nothing.
`default_nettype none
module ped_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/ped_front.sv =====
// Front end: accepts requests, masks positions and feeds a two-entry queue.
// Depends on ped_pkg.
`default_nettype none
module ped_front import ped_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     valid,
    output logic          ready,
    input  wire in_item_t in_item,
    output logic          cmd_valid,
    input  wire logic     cmd_ready,
    output cmd_t          cmd
);
    cmd_t       q_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg, rd_next, wr_reg, wr_next;
    cmd_t       in_cmd;
    logic       push, pop;

    assign in_cmd.mask = {in_item.mask_w7, in_item.mask_w6, in_item.mask_w5, in_item.mask_w4,
                          in_item.mask_w3, in_item.mask_w2, in_item.mask_w1, in_item.mask_w0}
                         & pos_limit();
    assign in_cmd.restart = in_item.restart;
    assign ready     = (cnt_reg != 2'd2);
    assign push      = valid && ready;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
        rd_next  = rd_reg ^ pop;
        wr_next  = wr_reg ^ push;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/ped_back.sv =====
// Back end: applies packets, stores pending ones in RAM and rescans them.
// Depends on ped_pkg, ped_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module ped_back import ped_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cmd_valid,
    output logic            cmd_ready,
    input  wire cmd_t       cmd,
    input  wire logic [8:0] target_len,
    output logic            out_valid,
    input  wire logic       out_ready,
    output out_item_t       out_item
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CNT   = 8'b0000_0010,
        S_DEC   = 8'b0000_0100,
        S_STORE = 8'b0000_1000,
        S_SCAN  = 8'b0001_0000,
        S_RD    = 8'b0010_0000,
        S_RCNT  = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } state_t;

    state_t                  state_reg, state_next;
    logic [MASK_BITS-1:0]    und_reg, und_next;
    logic [PENDING_SLOTS-1:0] pv_reg, pv_next;
    logic [8:0]              dec_reg, dec_next;
    logic [MASK_BITS-1:0]    pkt_reg, pkt_next;
    logic [1:0]              w_reg, w_next;
    logic [POP_W-1:0]        acc_reg, acc_next;
    logic [SLOT_W-1:0]       slot_reg, slot_next;
    logic                    chg_reg, chg_next;
    logic [8:0]              cnt_reg, cnt_next;
    logic                    ovf_reg, ovf_next;
    logic                    ov_reg, ov_next;
    out_item_t               res_reg, res_next;
    logic [63:0]             word, fresh;
    logic                    ram_we;
    logic [SLOT_W+1:0]       ram_addr;
    logic [63:0]             ram_rdata;
    logic [8:0]              target;
    logic [SLOT_W:0]         free_slot;
    logic [PEND_W-1:0]       pv_pop;
    logic                    last_w;

    ped_ram #(.WIDTH(64), .DEPTH(PENDING_SLOTS*4)) u_ram (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(pkt_reg[w_reg*64 +: 64]),
        .rdata(ram_rdata)
    );

    assign target = (target_len > 9'(NUM_POSITIONS)) ? 9'(NUM_POSITIONS) : target_len;
    assign last_w = (w_reg == 2'd3);
    assign word   = (state_reg == S_RCNT) ? ram_rdata : pkt_reg[w_reg*64 +: 64];
    assign fresh  = word & und_reg[w_reg*64 +: 64];

    always_comb
    begin
        free_slot = (SLOT_W+1)'(PENDING_SLOTS);
        for (int s = PENDING_SLOTS-1; s >= 0; s--)
        begin
            if (!pv_reg[s])
            begin
                free_slot = (SLOT_W+1)'(s);
            end
        end
        pv_pop = '0;
        for (int s = 0; s < PENDING_SLOTS; s++)
        begin
            pv_pop = pv_pop + PEND_W'(pv_reg[s]);
        end
    end

    assign cmd_ready = (state_reg == S_IDLE);
    assign out_valid = ov_reg;
    assign out_item  = res_reg;
    assign ram_we    = (state_reg == S_STORE);
    assign ram_addr  = {slot_reg, w_reg};

    always_comb
    begin
        state_next = state_reg;
        und_next   = und_reg;
        pv_next    = pv_reg;
        dec_next   = dec_reg;
        pkt_next   = pkt_reg;
        w_next     = w_reg;
        acc_next   = acc_reg;
        slot_next  = slot_reg;
        chg_next   = chg_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        ov_next    = ov_reg && !out_ready;
        res_next   = res_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    pkt_next = cmd.mask;
                    w_next   = '0;
                    acc_next = '0;
                    cnt_next = '0;
                    ovf_next = 1'b0;
                    if (cmd.restart)
                    begin
                        und_next = pos_limit();
                        pv_next  = '0;
                        dec_next = '0;
                    end
                    if ((cmd.restart ? 9'd0 : dec_reg) < target)
                    begin
                        state_next = S_CNT;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_CNT:
            begin
                acc_next = acc_reg + POP_W'(pop64(fresh));
                w_next   = w_reg + 2'd1;
                if (last_w)
                begin
                    cnt_next = acc_next;
                    if (acc_next == 9'd1)
                    begin
                        state_next = S_DEC;
                    end
                    else if (acc_next == 9'd0)
                    begin
                        state_next = S_OUT;
                    end
                    else if (free_slot[SLOT_W])
                    begin
                        ovf_next   = 1'b1;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        slot_next  = free_slot[SLOT_W-1:0];
                        state_next = S_STORE;
                    end
                end
            end
            S_DEC:
            begin
                und_next[w_reg*64 +: 64] = und_reg[w_reg*64 +: 64] & ~fresh;
                w_next = w_reg + 2'd1;
                if (last_w)
                begin
                    dec_next   = dec_reg + 9'd1;
                    slot_next  = '0;
                    chg_next   = 1'b0;
                    state_next = S_SCAN;
                end
            end
            S_STORE:
            begin
                w_next = w_reg + 2'd1;
                if (last_w)
                begin
                    pv_next[slot_reg] = 1'b1;
                    state_next        = S_OUT;
                end
            end
            S_SCAN:
            begin
                // Walk slots; valid ones are read one word at a time.
                if (pv_reg[slot_reg])
                begin
                    w_next     = '0;
                    acc_next   = '0;
                    state_next = S_RD;
                end
                else if (slot_reg == SLOT_W'(PENDING_SLOTS-1))
                begin
                    slot_next  = '0;
                    chg_next   = 1'b0;
                    state_next = chg_reg ? S_SCAN : S_OUT;
                end
                else
                begin
                    slot_next = slot_reg + SLOT_W'(1);
                end
            end
            S_RD:
            begin
                state_next = S_RCNT;
            end
            S_RCNT:
            begin
                acc_next = acc_reg + POP_W'(pop64(fresh));
                pkt_next[w_reg*64 +: 64] = fresh;
                w_next   = w_reg + 2'd1;
                state_next = S_RD;
                if (last_w)
                begin
                    if (acc_next == 9'd1)
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            und_next[k*64 +: 64] = und_reg[k*64 +: 64] & ~pkt_reg[k*64 +: 64];
                        end
                        und_next[3*64 +: 64] = und_reg[3*64 +: 64] & ~fresh;
                        dec_next = dec_reg + 9'd1;
                        chg_next = 1'b1;
                    end
                    if (acc_next <= 9'd1)
                    begin
                        pv_next[slot_reg] = 1'b0;
                    end
                    if (slot_reg == SLOT_W'(PENDING_SLOTS-1))
                    begin
                        slot_next  = '0;
                        chg_next   = 1'b0;
                        state_next = (chg_reg || acc_next == 9'd1) ? S_SCAN : S_OUT;
                    end
                    else
                    begin
                        slot_next  = slot_reg + SLOT_W'(1);
                        state_next = S_SCAN;
                    end
                end
            end
            S_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next                 = 1'b1;
                    res_next.new_info_count = cnt_reg;
                    res_next.decoded_count  = dec_reg;
                    res_next.pending_count  = pv_pop;
                    res_next.overflow       = ovf_reg;
                    res_next.complete       = (dec_reg >= target);
                    state_next              = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        pkt_reg  <= pkt_next;
        acc_reg  <= acc_next;
        cnt_reg  <= cnt_next;
        res_reg  <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            und_reg   <= pos_limit();
            pv_reg    <= '0;
            dec_reg   <= '0;
            w_reg     <= '0;
            slot_reg  <= '0;
            chg_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            und_reg   <= und_next;
            pv_reg    <= pv_next;
            dec_reg   <= dec_next;
            w_reg     <= w_next;
            slot_reg  <= slot_next;
            chg_reg   <= chg_next;
            ovf_reg   <= ovf_next;
            ov_reg    <= ov_next;
        end
    end

    `ASSERT_CLK(a_onehot, clk, rst_n, $onehot(state_reg), "state not one-hot")
    `ASSERT_CLK(a_hold, clk, rst_n, (out_valid && !out_ready) |=> $stable(out_item),
                "result changed while stalled")
    `ASSERT_CLK(a_dec_mono, clk, rst_n,
                (state_reg != S_IDLE) |=> (dec_reg >= $past(dec_reg)),
                "decoded count fell during a step")
    `ASSERT_NEVER(a_no_we_idle, clk, rst_n, ram_we && cmd_ready, "RAM written while idle")
endmodule
`default_nettype wire
